// ===== hdl/dht_pkg.sv =====
// Shared types, codes and the microcode program of the double hashing table.
`default_nettype none

package dht_pkg;

    // Default sizing
    localparam int TABLE_SIZE_DEF   = 16;
    localparam int STEP_MODULUS_DEF = 7;
    localparam int KEY_WIDTH_DEF    = 31;

    // Key bits folded into the remainders per cycle
    localparam int DIGIT_BITS = 4;

    localparam int OP_WIDTH     = 2;
    localparam int STATUS_WIDTH = 2;
    localparam int SLOT_WIDTH   = 4;
    localparam int UPC_WIDTH    = 4;

    localparam logic [OP_WIDTH-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_NO_ROOM   = 2'd2;

    // Program addresses
    localparam logic [UPC_WIDTH-1:0] S_CLEAR   = 4'd0;
    localparam logic [UPC_WIDTH-1:0] S_IDLE    = 4'd1;
    localparam logic [UPC_WIDTH-1:0] S_REDUCE  = 4'd2;
    localparam logic [UPC_WIDTH-1:0] S_SETUP   = 4'd3;
    localparam logic [UPC_WIDTH-1:0] S_STEPRED = 4'd4;
    localparam logic [UPC_WIDTH-1:0] S_PRIME   = 4'd5;
    localparam logic [UPC_WIDTH-1:0] S_PROBE   = 4'd6;
    localparam logic [UPC_WIDTH-1:0] S_DECIDE  = 4'd7;
    localparam logic [UPC_WIDTH-1:0] S_MISS    = 4'd8;
    localparam logic [UPC_WIDTH-1:0] S_COMMIT  = 4'd9;

    // Datapath action of one step
    typedef enum logic [3:0] {
        A_NONE    = 4'd0,
        A_CLEAR   = 4'd1,
        A_LOAD    = 4'd2,
        A_DIGIT   = 4'd3,
        A_SETUP   = 4'd4,
        A_STEPRED = 4'd5,
        A_PRIME   = 4'd6,
        A_PROBE   = 4'd7,
        A_MISS    = 4'd8,
        A_COMMIT  = 4'd9
    } t_act;

    // Jump condition of one step
    typedef enum logic [3:0] {
        C_NEVER     = 4'd0,
        C_ALWAYS    = 4'd1,
        C_IN        = 4'd2,
        C_CLR_DONE  = 4'd3,
        C_DIG_LAST  = 4'd4,
        C_BAD_OP    = 4'd5,
        C_STEP_OK   = 4'd6,
        C_PROBE_END = 4'd7,
        C_HIT       = 4'd8,
        C_OUT_FREE  = 4'd9
    } t_cond;

    // Jump if cond holds; otherwise stay when stay is set, else fall through.
    typedef struct packed {
        t_act                 act;
        t_cond                cond;
        logic [UPC_WIDTH-1:0] jmp;
        logic                 stay;
    } t_uword;

    // Status flags the datapath offers to the sequencer
    typedef struct packed {
        logic in_valid;
        logic clr_done;
        logic dig_last;
        logic bad_op;
        logic step_ok;
        logic probe_end;
        logic hit;
        logic out_free;
    } t_conds;

    function automatic t_uword ucode_word(input logic [UPC_WIDTH-1:0] addr);
        t_uword w;
        case (addr)
            S_CLEAR:   w = '{act: A_CLEAR,   cond: C_CLR_DONE,  jmp: S_IDLE,   stay: 1'b1};
            S_IDLE:    w = '{act: A_LOAD,    cond: C_IN,        jmp: S_REDUCE, stay: 1'b1};
            S_REDUCE:  w = '{act: A_DIGIT,   cond: C_DIG_LAST,  jmp: S_SETUP,  stay: 1'b1};
            S_SETUP:   w = '{act: A_SETUP,   cond: C_BAD_OP,    jmp: S_MISS,   stay: 1'b0};
            S_STEPRED: w = '{act: A_STEPRED, cond: C_STEP_OK,   jmp: S_PRIME,  stay: 1'b1};
            S_PRIME:   w = '{act: A_PRIME,   cond: C_NEVER,     jmp: S_IDLE,   stay: 1'b0};
            S_PROBE:   w = '{act: A_PROBE,   cond: C_PROBE_END, jmp: S_DECIDE, stay: 1'b1};
            S_DECIDE:  w = '{act: A_NONE,    cond: C_HIT,       jmp: S_COMMIT, stay: 1'b0};
            S_MISS:    w = '{act: A_MISS,    cond: C_OUT_FREE,  jmp: S_IDLE,   stay: 1'b1};
            S_COMMIT:  w = '{act: A_COMMIT,  cond: C_OUT_FREE,  jmp: S_IDLE,   stay: 1'b1};
            default:   w = '{act: A_NONE,    cond: C_ALWAYS,    jmp: S_IDLE,   stay: 1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dht_modred.sv =====
// Radix 2^DIGIT_BITS remainder accumulator: key mod a constant, digit by digit.
`default_nettype none

module dht_modred
    import dht_pkg::*;
#(
    parameter int MODULUS = STEP_MODULUS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_clear,
    input  wire                          i_shift,
    input  wire [DIGIT_BITS-1:0]         i_digit,
    output logic [$clog2(MODULUS)-1:0]   o_rem
);

    localparam int RW = $clog2(MODULUS);
    localparam int AW = RW + DIGIT_BITS + 1;

    logic [RW-1:0] r_rem;
    logic [RW-1:0] n_rem;
    logic [AW-1:0] acc;

    // Restoring reduction: acc < MODULUS * 2^DIGIT_BITS going in.
    always_comb begin
        acc = {1'b0, r_rem, i_digit};
        for (int j = DIGIT_BITS - 1; j >= 0; j--) begin
            if (acc >= (AW'(MODULUS) << j)) begin
                acc = acc - (AW'(MODULUS) << j);
            end
        end
        n_rem = acc[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_rem <= '0;
        end else if (i_shift) begin
            r_rem <= n_rem;
        end
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire

// ===== hdl/dht_store.sv =====
// Slot memory: valid bit and key per slot, one write and one registered read port.
`default_nettype none

module dht_store
    import dht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_we,
    input  wire [$clog2(TABLE_SIZE)-1:0]  i_waddr,
    input  wire [KEY_WIDTH:0]             i_wdata,
    input  wire [$clog2(TABLE_SIZE)-1:0]  i_raddr,
    output logic [KEY_WIDTH:0]            o_rdata
);

    logic [KEY_WIDTH:0] mem [TABLE_SIZE];
    logic [KEY_WIDTH:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/dht_sequencer.sv =====
// Microcode sequencer: step counter, program ROM and conditional jumps.
`default_nettype none

module dht_sequencer
    import dht_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_conds  i_conds,
    output t_act         o_act,
    output logic         o_idle
);

    logic [UPC_WIDTH-1:0] r_upc;
    logic [UPC_WIDTH-1:0] n_upc;
    t_uword               word;
    logic                 take;

    always_comb begin
        word = ucode_word(r_upc);
        case (word.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_IN:        take = i_conds.in_valid;
            C_CLR_DONE:  take = i_conds.clr_done;
            C_DIG_LAST:  take = i_conds.dig_last;
            C_BAD_OP:    take = i_conds.bad_op;
            C_STEP_OK:   take = i_conds.step_ok;
            C_PROBE_END: take = i_conds.probe_end;
            C_HIT:       take = i_conds.hit;
            C_OUT_FREE:  take = i_conds.out_free;
            default:     take = 1'b1;
        endcase
        if (take) begin
            n_upc = word.jmp;
        end else if (word.stay) begin
            n_upc = r_upc;
        end else begin
            n_upc = r_upc + UPC_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_CLEAR;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_act  = word.act;
    assign o_idle = (r_upc == S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/double_hash_table.sv =====
// Double hashing table top level: datapath around the microcoded sequencer.
//
// Use: one input channel (i_valid / o_stall, fields i_op, i_key) and one result
// channel (o_valid / i_stall, fields o_status, o_slot, o_table_full,
// o_table_empty). A beat is taken at a rising edge with valid high and stall low.
// Every input beat yields exactly one result beat, in order.
// op: insert writes the first free slot on the probe path (duplicates allowed),
// search reports the first slot holding the key, delete frees that slot. Op code
// 3 touches nothing and answers "not found".
// One item at a time. Steps from input beat to result: remainder steps over the
//   key digits, setup, step reduction (repeated while the step is not below
//   TABLE_SIZE), prime, probe steps (one slot read per cycle on the memory's
//   read port) until a hit or the last probe, decide, then commit or miss; an
//   unused op code goes from setup straight to miss. Then back to idle.
// Reset: a clearing pass writes every slot empty with o_stall high; occupancy
// starts at zero and the result register is empty.
// A result waits in the output register while i_stall is high; the next item
// is taken meanwhile and runs up to its commit or miss step, which waits for room.
`default_nettype none

module double_hash_table
    import dht_pkg::*;
#(
    parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
    parameter int STEP_MODULUS = STEP_MODULUS_DEF,
    parameter int KEY_WIDTH    = KEY_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire [OP_WIDTH-1:0]       i_op,
    input  wire [KEY_WIDTH-1:0]      i_key,
    output logic                     o_valid,
    input  wire                      i_stall,
    output logic [STATUS_WIDTH-1:0]  o_status,
    output logic [SLOT_WIDTH-1:0]    o_slot,
    output logic                     o_table_full,
    output logic                     o_table_empty
);

    localparam int PW     = $clog2(TABLE_SIZE);          // slot index
    localparam int CW     = $clog2(TABLE_SIZE + 2);      // probe count 0..N+1
    localparam int OW     = $clog2(TABLE_SIZE + 1);      // occupancy 0..N
    localparam int RW7    = $clog2(STEP_MODULUS);        // key mod STEP_MODULUS
    localparam int SW     = $clog2(STEP_MODULUS + 1);    // step 1..STEP_MODULUS
    localparam int NW     = $clog2(TABLE_SIZE + 1);
    localparam int XW     = (SW > NW) ? SW : NW;         // step vs. table size
    localparam int DCOUNT = (KEY_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int KPW    = DCOUNT * DIGIT_BITS;
    localparam int DCW    = $clog2(DCOUNT + 1);

    // Sequencer hookup
    t_act   act;
    t_conds conds;
    logic   seq_idle;

    // Item registers
    logic [OP_WIDTH-1:0]  r_op;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KPW-1:0]       r_kshift;   // key digits, most significant first
    logic [DCW-1:0]       r_dcnt;

    // Probe registers
    logic [PW-1:0]  r_pos;            // next address to read; clear pointer too
    logic [PW-1:0]  r_chk_pos;        // address whose data is on the read port
    logic [SW-1:0]  r_step;
    logic [CW-1:0]  r_cnt;
    logic           r_hit;
    logic [PW-1:0]  r_slot;

    logic [OW-1:0]  r_occ;
    logic [OW-1:0]  n_occ;

    // Result register
    logic                     r_out_valid;
    logic [STATUS_WIDTH-1:0]  r_status;
    logic [SLOT_WIDTH-1:0]    r_slot_out;
    logic                     r_full;
    logic                     r_empty;

    // Remainders
    logic [PW-1:0]          home_rem;
    logic [RW7-1:0]         step_rem;
    logic [DIGIT_BITS-1:0]  digit;

    // Memory ports
    logic                 mem_we;
    logic [PW-1:0]        mem_waddr;
    logic [KEY_WIDTH:0]   mem_wdata;
    logic [KEY_WIDTH:0]   mem_rdata;

    logic           accept_in;
    logic           out_free;
    logic           is_insert;
    logic           hit_now;
    logic           last_probe;
    logic [PW:0]    pos_sum;
    logic [PW-1:0]  pos_next;
    logic           step_ok;
    logic           finish;

    assign accept_in = i_valid && seq_idle;
    assign out_free  = !r_out_valid || !i_stall;
    assign is_insert = (r_op == OP_INSERT);
    assign digit     = r_kshift[KPW-1 -: DIGIT_BITS];

    // Next probe position: step is already below TABLE_SIZE.
    always_comb begin
        pos_sum = {1'b0, r_pos} + {1'b0, PW'(r_step)};
        if (pos_sum >= (PW+1)'(TABLE_SIZE)) begin
            pos_sum = pos_sum - (PW+1)'(TABLE_SIZE);
        end
        pos_next = pos_sum[PW-1:0];
    end

    assign step_ok = (XW'(r_step) < XW'(TABLE_SIZE));

    // Hit test on the slot read last cycle
    assign hit_now = is_insert ? !mem_rdata[KEY_WIDTH]
                               : (mem_rdata[KEY_WIDTH] && (mem_rdata[KEY_WIDTH-1:0] == r_key));
    assign last_probe = (r_cnt == CW'(TABLE_SIZE + 1));

    always_comb begin
        conds.in_valid  = i_valid;
        conds.clr_done  = (r_pos == PW'(TABLE_SIZE - 1));
        conds.dig_last  = (r_dcnt == DCW'(DCOUNT - 1));
        conds.bad_op    = (r_op != OP_INSERT) && (r_op != OP_SEARCH) && (r_op != OP_DELETE);
        conds.step_ok   = step_ok;
        conds.probe_end = hit_now || last_probe;
        conds.hit       = r_hit;
        conds.out_free  = out_free;
    end

    dht_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_conds (conds),
        .o_act   (act),
        .o_idle  (seq_idle)
    );

    dht_modred #(.MODULUS(TABLE_SIZE)) u_home (
        .i_clk   (i_clk),
        .i_clear (act == A_LOAD),
        .i_shift (act == A_DIGIT),
        .i_digit (digit),
        .o_rem   (home_rem)
    );

    dht_modred #(.MODULUS(STEP_MODULUS)) u_step (
        .i_clk   (i_clk),
        .i_clear (act == A_LOAD),
        .i_shift (act == A_DIGIT),
        .i_digit (digit),
        .o_rem   (step_rem)
    );

    // Memory writes: clearing pass, or the commit of an insert or delete.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = {1'b1, r_key};
        if (act == A_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_pos;
            mem_wdata = '0;
        end else if (act == A_COMMIT && out_free && r_op != OP_SEARCH) begin
            mem_we    = 1'b1;
            mem_wdata = {is_insert, r_key};
        end
    end

    dht_store #(.TABLE_SIZE(TABLE_SIZE), .KEY_WIDTH(KEY_WIDTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_pos),
        .o_rdata (mem_rdata)
    );

    // Occupancy after this item
    always_comb begin
        n_occ = r_occ;
        if (act == A_COMMIT && out_free) begin
            if (r_op == OP_INSERT) begin
                n_occ = r_occ + OW'(1);
            end else if (r_op == OP_DELETE) begin
                n_occ = r_occ - OW'(1);
            end
        end
    end

    assign finish = (act == A_MISS || act == A_COMMIT) && out_free;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_occ <= n_occ;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (act)
                A_CLEAR:            r_pos <= r_pos + PW'(1);
                A_SETUP:            r_pos <= home_rem;
                A_PRIME, A_PROBE:   r_pos <= pos_next;
                default:            r_pos <= r_pos;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (act)
            A_LOAD: begin
                if (accept_in) begin
                    r_op     <= i_op;
                    r_key    <= i_key;
                    r_kshift <= KPW'(i_key);
                    r_dcnt   <= '0;
                end
            end
            A_DIGIT: begin
                r_kshift <= r_kshift << DIGIT_BITS;
                r_dcnt   <= r_dcnt + DCW'(1);
            end
            A_SETUP: begin
                r_step <= SW'(STEP_MODULUS) - SW'(step_rem);
            end
            A_STEPRED: begin
                if (!step_ok) begin
                    r_step <= r_step - SW'(TABLE_SIZE);
                end
            end
            A_PRIME: begin
                r_chk_pos <= r_pos;
                r_cnt     <= CW'(1);
                r_hit     <= 1'b0;
            end
            A_PROBE: begin
                r_chk_pos <= r_pos;
                r_cnt     <= r_cnt + CW'(1);
                if (hit_now) begin
                    r_hit  <= 1'b1;
                    r_slot <= r_chk_pos;
                end
            end
            default: begin
            end
        endcase

        if (finish) begin
            r_full  <= (n_occ >= OW'(TABLE_SIZE));
            r_empty <= (n_occ == '0);
            if (act == A_COMMIT) begin
                r_status   <= ST_OK;
                r_slot_out <= SLOT_WIDTH'(r_slot);
            end else begin
                r_status   <= is_insert ? ST_NO_ROOM : ST_NOT_FOUND;
                r_slot_out <= '0;
            end
        end
    end

    assign o_stall       = !seq_idle;
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_slot        = r_slot_out;
    assign o_table_full  = r_full;
    assign o_table_empty = r_empty;

endmodule

`default_nettype wire

// ===== dv/dht_checker.sv =====
// Result checker for the double hashing table: predicts every answer and compares it.
`timescale 1ns / 100ps

module dht_checker
    import dht_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // input channel as seen at the block
    input  wire                     in_valid,
    input  wire                     in_stall,
    input  wire [OP_WIDTH-1:0]      in_op,
    input  wire [KEY_WIDTH_DEF-1:0] in_key,
    // result channel as seen at the block
    input  wire                     out_valid,
    input  wire                     out_stall,
    input  wire [STATUS_WIDTH-1:0]  out_status,
    input  wire [SLOT_WIDTH-1:0]    out_slot,
    input  wire                     out_full,
    input  wire                     out_empty,
    // totals for the top
    output int                      fail_count,
    output int                      pending_answers,
    output int                      answers_checked,
    output int                      full_seen,
    output int                      no_room_seen,
    output int                      misses_seen
);

    typedef struct packed {
        logic [STATUS_WIDTH-1:0] status;
        logic [SLOT_WIDTH-1:0]   slot;
        logic                    full;
        logic                    empty;
    } t_table_answer;

    // shadow copy of the table
    logic [KEY_WIDTH_DEF-1:0] stored_key [TABLE_SIZE_DEF];
    logic                     slot_used  [TABLE_SIZE_DEF];
    int                       occupied;

    t_table_answer answer_q[$];

    // i-th position on the double hashing probe path of key
    function automatic int probe_slot(input logic [KEY_WIDTH_DEF-1:0] key, input int i);
        int home;
        int stride;
        home   = key % TABLE_SIZE_DEF;
        stride = STEP_MODULUS_DEF - key % STEP_MODULUS_DEF;
        return (home + i * stride) % TABLE_SIZE_DEF;
    endfunction

    // Applies one operation to the shadow table and returns the answer it must give.
    function automatic t_table_answer apply_table_op(input logic [OP_WIDTH-1:0] op,
                                                     input logic [KEY_WIDTH_DEF-1:0] key);
        t_table_answer ans;
        int            p;
        int            i;
        bit            done;
        ans.status = ST_NOT_FOUND;
        ans.slot   = '0;
        done       = 1'b0;
        case (op)
            OP_INSERT: begin
                ans.status = ST_NO_ROOM;
                for (i = 0; i <= TABLE_SIZE_DEF && !done; i++) begin
                    p = probe_slot(key, i);
                    if (!slot_used[p]) begin
                        stored_key[p] = key;
                        slot_used[p]  = 1'b1;
                        occupied++;
                        ans.status = ST_OK;
                        ans.slot   = SLOT_WIDTH'(p);
                        done       = 1'b1;
                    end
                end
            end
            OP_SEARCH, OP_DELETE: begin
                for (i = 0; i <= TABLE_SIZE_DEF && !done; i++) begin
                    p = probe_slot(key, i);
                    if (slot_used[p] && stored_key[p] == key) begin
                        if (op == OP_DELETE) begin
                            slot_used[p] = 1'b0;
                            if (occupied > 0) occupied--;
                        end
                        ans.status = ST_OK;
                        ans.slot   = SLOT_WIDTH'(p);
                        done       = 1'b1;
                    end
                end
            end
            default: ;  // unused code: no change, reports not found
        endcase
        ans.full  = (occupied >= TABLE_SIZE_DEF);
        ans.empty = (occupied == 0);
        return ans;
    endfunction

    function automatic int field_differs(input string name, input logic [3:0] want_v,
                                         input logic [3:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_table_answer want;
        t_table_answer got;
        int            errs;
        int            k;
        errs = 0;
        if (!i_rst_n) begin
            for (k = 0; k < TABLE_SIZE_DEF; k++) slot_used[k] = 1'b0;
            occupied = 0;
            answer_q.delete();
            fail_count      <= 0;
            pending_answers <= 0;
            answers_checked <= 0;
            full_seen       <= 0;
            no_room_seen    <= 0;
            misses_seen     <= 0;
        end else begin
            // result first: it always belongs to an older beat than one taken now
            if (out_valid && !out_stall) begin
                got = '{status: out_status, slot: out_slot, full: out_full, empty: out_empty};
                answers_checked <= answers_checked + 1;
                if (answer_q.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding, expected none got %h",
                             $time, got);
                    errs++;
                end else begin
                    want = answer_q.pop_front();
                    errs += field_differs("status", 4'(want.status), 4'(got.status));
                    errs += field_differs("slot", want.slot, got.slot);
                    errs += field_differs("table_full", 4'(want.full), 4'(got.full));
                    errs += field_differs("table_empty", 4'(want.empty), 4'(got.empty));
                end
            end
            if (in_valid && !in_stall) begin
                want = apply_table_op(in_op, in_key);
                answer_q.push_back(want);
                if (want.full) full_seen <= full_seen + 1;
                if (want.status == ST_NO_ROOM) no_room_seen <= no_room_seen + 1;
                if (want.status == ST_NOT_FOUND) misses_seen <= misses_seen + 1;
            end
            fail_count      <= fail_count + errs;
            pending_answers <= answer_q.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Top of the double hashing table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import dht_pkg::*;

    // op code the block leaves unused; it must answer "not found" and change nothing
    localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;

    localparam logic [KEY_WIDTH_DEF-1:0] KEY_MAX = '1;

    localparam int RANDOM_OPS   = 1080;
    localparam int PHASE_LEN    = 120;      // beats per fill or drain phase
    localparam int POOL_SIZE    = 24;
    localparam int IDLE_PCT     = 6;
    localparam int QUIET_FIRST  = 400;      // random beats in this window see no idling
    localparam int QUIET_LAST   = 650;
    localparam int DRAIN_CYCLES = 40;       // > worst case latency
    // covers every op plus idling on both sides with a wide margin
    localparam int CYCLE_LIMIT  = 600000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [OP_WIDTH-1:0]      i_op;
    logic [KEY_WIDTH_DEF-1:0] i_key;
    logic                     o_valid;
    logic                     i_stall;
    logic [STATUS_WIDTH-1:0]  o_status;
    logic [SLOT_WIDTH-1:0]    o_slot;
    logic                     o_table_full;
    logic                     o_table_empty;

    int  fail_count;
    int  pending_answers;
    int  answers_checked;
    int  full_seen;
    int  no_room_seen;
    int  misses_seen;

    int  cycle_count = 0;
    bit  quiet = 1'b0;           // both sides stop idling while set
    int  op_tally [4];           // beats sent per op code

    logic [KEY_WIDTH_DEF-1:0] key_pool [POOL_SIZE];

    double_hash_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_table_full  (o_table_full),
        .o_table_empty (o_table_empty)
    );

    dht_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .in_valid        (i_valid),
        .in_stall        (o_stall),
        .in_op           (i_op),
        .in_key          (i_key),
        .out_valid       (o_valid),
        .out_stall       (i_stall),
        .out_status      (o_status),
        .out_slot        (o_slot),
        .out_full        (o_table_full),
        .out_empty       (o_table_empty),
        .fail_count      (fail_count),
        .pending_answers (pending_answers),
        .answers_checked (answers_checked),
        .full_seen       (full_seen),
        .no_room_seen    (no_room_seen),
        .misses_seen     (misses_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Result side: random backpressure, about 6 percent of the time, none in the quiet window.
    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // Send one beat. Random idle cycles go in front; once valid is up the payload
    // holds until the beat is taken. Returns at the edge that takes the beat.
    task automatic send_beat(input logic [OP_WIDTH-1:0] op,
                             input logic [KEY_WIDTH_DEF-1:0] key);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        @(posedge i_clk);
        // o_stall read here is the value the edge just sampled
        while (o_stall) @(posedge i_clk);
        op_tally[op]++;
    endtask

    // Random op mix: fill phases lean on insert, drain phases on delete,
    // so occupancy swings between empty and full across the run.
    task automatic send_random(input int n);
        int pick;
        logic [OP_WIDTH-1:0]      op;
        logic [KEY_WIDTH_DEF-1:0] key;
        pick = $urandom_range(99);
        if ((n / PHASE_LEN) % 2 == 0)
            op = (pick < 55) ? OP_INSERT : (pick < 75) ? OP_SEARCH :
                 (pick < 95) ? OP_DELETE : OP_UNUSED;
        else
            op = (pick < 20) ? OP_INSERT : (pick < 45) ? OP_SEARCH :
                 (pick < 95) ? OP_DELETE : OP_UNUSED;
        // mostly pool keys so lookups hit and duplicates pile up; some fresh keys
        pick = $urandom_range(99);
        if (pick < 85)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else if (pick < 93)
            key = KEY_WIDTH_DEF'($urandom_range(255));
        else
            key = KEY_WIDTH_DEF'($urandom());
        send_beat(op, key);
    endtask

    initial begin
        int n;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op    <= OP_INSERT;
        i_key   <= '0;
        i_stall <= 1'b0;
        for (n = 0; n < 4; n++) op_tally[n] = 0;

        // pool: key zero, small keys (crowded homes, short even strides that
        // reach only part of the table), and full width keys
        key_pool[0] = '0;
        for (n = 1; n < POOL_SIZE; n++)
            key_pool[n] = (n < 16) ? KEY_WIDTH_DEF'($urandom_range(63))
                                   : KEY_WIDTH_DEF'($urandom());

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the clearing pass after reset shows up as o_stall; send_beat waits it out

        // --- directed ---
        send_beat(OP_UNUSED, '0);       // unused code on an empty table
        send_beat(OP_SEARCH, '0);       // search on an empty table
        send_beat(OP_DELETE, KEY_MAX);  // delete of an absent key
        send_beat(OP_INSERT, KEY_MAX);  // all-ones key, even stride
        send_beat(OP_SEARCH, KEY_MAX);
        // 15 copies of key zero (stride 7 visits every slot) fill the table
        for (n = 0; n < TABLE_SIZE_DEF - 1; n++) send_beat(OP_INSERT, '0);
        send_beat(OP_INSERT, KEY_WIDTH_DEF'(5));   // no free slot left
        send_beat(OP_SEARCH, '0);                  // search while full
        send_beat(OP_UNUSED, KEY_MAX);             // unused code while full
        send_beat(OP_DELETE, KEY_MAX);
        send_beat(OP_DELETE, '0);

        // --- random ---
        for (n = 0; n < RANDOM_OPS; n++) begin
            quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
            send_random(n);
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        // let the checker's count of outstanding answers catch up, then drain
        @(posedge i_clk);
        while (pending_answers != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d ops: %0d insert, %0d search, %0d delete, %0d unused code;",
                 op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
                 op_tally[OP_INSERT], op_tally[OP_SEARCH], op_tally[OP_DELETE],
                 op_tally[OP_UNUSED]);
        $display("%0d answers checked. Table full after %0d ops, %0d inserts refused,",
                 answers_checked, full_seen, no_room_seen);
        $display("%0d lookups or ops missed.", misses_seen);
        if (fail_count == 0 && pending_answers == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dht_pkg.sv
hdl/dht_modred.sv
hdl/dht_store.sv
hdl/dht_sequencer.sv
hdl/double_hash_table.sv
dv/dht_checker.sv
dv/tb_top.sv
